/* rtl/sdse_pkg.sv */
// Shared types, constants and the segment table for the signed decimal display encoder.
`timescale 1ns / 1ps
package sdse_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 6;
  localparam int unsigned BinWidth   = 20;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned DabSteps   = 5;
  localparam int unsigned SegWidth   = 8;
  localparam int unsigned InWidth    = 32;
  localparam int unsigned OutWidth   = 56;

  localparam logic [ValueWidth-1:0] MaxShown = 32'd999999;
  localparam logic [SegWidth-1:0]   EPattern = 8'h9F;
  localparam logic [SegWidth-1:0]   Blank    = 8'h00;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } mag_t;

  typedef struct packed {
    logic                neg;
    logic                over;
    logic [BcdWidth-1:0] bcd;
    logic [BinWidth-1:0] bin;
  } dab_t;

  function automatic logic [SegWidth-1:0] seg_lut(input logic [3:0] digit);
    logic [SegWidth-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hFC;
      4'd1:    seg = 8'h60;
      4'd2:    seg = 8'hDB;
      4'd3:    seg = 8'hF3;
      4'd4:    seg = 8'h67;
      4'd5:    seg = 8'hB7;
      4'd6:    seg = 8'hBF;
      4'd7:    seg = 8'hE4;
      4'd8:    seg = 8'hFF;
      4'd9:    seg = 8'hF7;
      default: seg = Blank;
    endcase
    return seg;
  endfunction

endpackage

/* rtl/sdse_mag.sv */
// First stage: sign detection and two's complement magnitude.
`timescale 1ns / 1ps
module sdse_mag import sdse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output mag_t                  data_o
);

  logic valid_q;
  mag_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  // The most negative value maps to 2^31, which still fits unsigned.
  always_comb begin
    data_d.neg = value_i[ValueWidth-1];
    data_d.mag = value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/sdse_range.sv */
// Range check against the six-digit limit and setup of the conversion word.
`timescale 1ns / 1ps
module sdse_range import sdse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  mag_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output dab_t data_o
);

  logic valid_q;
  dab_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.neg  = data_i.neg;
    data_d.over = data_i.mag > MaxShown;
    data_d.bcd  = '0;
    data_d.bin  = data_i.mag[BinWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/sdse_dabble.sv */
// One pipeline stage of the shift-and-add-three binary to decimal conversion.
`timescale 1ns / 1ps
module sdse_dabble import sdse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dab_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output dab_t data_o
);

  logic valid_q;
  dab_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  // Each step corrects every decimal digit of 5 or more, then shifts one
  // binary bit into the decimal register.
  always_comb begin
    logic [BcdWidth-1:0] bcd;
    logic [BinWidth-1:0] bin;
    bcd = data_i.bcd;
    bin = data_i.bin;
    for (int s = 0; s < DabSteps; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BcdWidth-2:0], bin[BinWidth-1]};
      bin = {bin[BinWidth-2:0], 1'b0};
    end
    data_d.neg  = data_i.neg;
    data_d.over = data_i.over;
    data_d.bcd  = bcd;
    data_d.bin  = bin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/sdse_seg.sv */
// Final stage: segment lookup, leading-zero blanking and the output register.
`timescale 1ns / 1ps
module sdse_seg import sdse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  dab_t                data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutWidth-1:0] data_o
);

  logic                valid_q;
  logic [OutWidth-1:0] data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  // Digits are walked from the most significant one; a position lights once
  // a nonzero digit has been seen, and the units position always lights.
  always_comb begin
    logic [SegWidth-1:0] segs [NumDigits];
    logic                seen;
    logic [3:0]          digit;
    seen = 1'b0;
    for (int k = NumDigits - 1; k >= 0; k--) begin
      digit = data_i.bcd[4*k +: 4];
      seen  = seen || (digit != 4'd0) || (k == 0);
      if (data_i.over) begin
        segs[NumDigits-1-k] = (k == 0) ? EPattern : Blank;
      end else begin
        segs[NumDigits-1-k] = seen ? seg_lut(digit) : Blank;
      end
    end
    data_d = '0;
    for (int p = 0; p < NumDigits; p++) begin
      data_d[SegWidth*p +: SegWidth] = segs[p];
    end
    data_d[SegWidth*NumDigits]     = data_i.neg;
    data_d[SegWidth*NumDigits + 1] = data_i.over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/signed_decimal_seven_segment_encoder_unit.sv */
// Top level of the signed decimal seven-segment encoder.
`timescale 1ns / 1ps
// Each input word is a signed 32-bit value; each output word carries six
// seven-segment bytes (leftmost position first), a minus flag and an overflow
// flag. Magnitudes above 999999 show only an E in the rightmost position with
// overflow set, and leading zeros are blank. The block is a seven-stage
// pipeline (magnitude, range check, four conversion stages of five bit steps
// each, segment encoding) that accepts one word per cycle while the output
// side keeps up. A stall on the output holds every full stage; empty stages
// still fill.
module signed_decimal_seven_segment_encoder_unit import sdse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InWidth-1:0]  s_axis_tdata,  // [31:0] value
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] digit_one, [15:8] digit_two, [23:16] digit_three, [31:24] digit_four,
  // [39:32] digit_five, [47:40] digit_six, [48] minus_on, [49] overflow,
  // [55:50] zero
  output logic [OutWidth-1:0] m_axis_tdata
);

  localparam int unsigned NumDab = BinWidth / DabSteps;

  logic mag_valid, mag_ready;
  mag_t mag_data;
  logic dab_valid [NumDab+1];
  logic dab_ready [NumDab+1];
  dab_t dab_data  [NumDab+1];

  sdse_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i (s_axis_tdata[ValueWidth-1:0]),
    .valid_o (mag_valid),
    .ready_i (mag_ready),
    .data_o  (mag_data)
  );

  sdse_range u_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mag_valid),
    .ready_o (mag_ready),
    .data_i  (mag_data),
    .valid_o (dab_valid[0]),
    .ready_i (dab_ready[0]),
    .data_o  (dab_data[0])
  );

  for (genvar g = 0; g < NumDab; g++) begin : g_dab
    sdse_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dab_valid[g]),
      .ready_o (dab_ready[g]),
      .data_i  (dab_data[g]),
      .valid_o (dab_valid[g+1]),
      .ready_i (dab_ready[g+1]),
      .data_o  (dab_data[g+1])
    );
  end

  sdse_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dab_valid[NumDab]),
    .ready_o (dab_ready[NumDab]),
    .data_i  (dab_data[NumDab]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

  // An empty output register makes every stage ready, so input is taken.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready although the output stage is empty");

  a_overflow_shows_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[49]) |->
      (m_axis_tdata[47:40] == EPattern) && (m_axis_tdata[39:0] == '0))
    else $error("overflow word does not show a lone E");

  a_units_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:40] != Blank))
    else $error("rightmost position is blank");

  a_no_inner_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[49] && (m_axis_tdata[7:0] != Blank)) |->
      (m_axis_tdata[15:8] != Blank) && (m_axis_tdata[23:16] != Blank) &&
      (m_axis_tdata[31:24] != Blank) && (m_axis_tdata[39:32] != Blank))
    else $error("blank position after a lit leftmost digit");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the signed decimal seven-segment display encoder.
`timescale 1ns / 1ps
module tb_top;
  import sdse_pkg::*;

  localparam int unsigned LongHold   = 120;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned NumRandom  = 1028;
  localparam realtime     RunLimit   = 5ms;

  localparam logic [SegWidth-1:0] SegOfDigit [10] = '{
    8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE4, 8'hFF, 8'hF7
  };

  // Output word as it appears on m_axis_tdata, highest field first.
  typedef struct packed {
    logic [5:0]          zero;
    logic                overflow;
    logic                minus_on;
    logic [SegWidth-1:0] digit_six;
    logic [SegWidth-1:0] digit_five;
    logic [SegWidth-1:0] digit_four;
    logic [SegWidth-1:0] digit_three;
    logic [SegWidth-1:0] digit_two;
    logic [SegWidth-1:0] digit_one;
  } display_t;

  typedef struct {
    logic [ValueWidth-1:0] value;
    int unsigned           idle_before;
    bit                    drain_before;
  } value_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  value_item_t values_to_send[$];
  display_t    pending_displays[$];

  int unsigned idle_count;
  int unsigned sent_count;
  int unsigned shown_count;
  int unsigned negative_count;
  int unsigned overflow_count;
  int unsigned mismatches;

  int unsigned results_taken;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned held_at;

  signed_decimal_seven_segment_encoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] value
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // digits one..six, minus_on, overflow, zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short idle stretches with the occasional long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Works out the display for one value: blank, then either E on the right
  // or the decimal digits filled in from the right without leading zeros.
  function automatic display_t encode_display(logic [ValueWidth-1:0] value);
    display_t              disp;
    logic [ValueWidth-1:0] mag;
    logic [SegWidth-1:0]   segs [NumDigits];
    bit                    done;
    disp = '0;
    disp.minus_on = value[ValueWidth-1];
    mag = value[ValueWidth-1] ? -value : value;
    for (int k = 0; k < NumDigits; k++) segs[k] = Blank;
    if (mag > MaxShown) begin
      disp.overflow = 1'b1;
      segs[NumDigits-1] = EPattern;
    end else begin
      done = 1'b0;
      for (int k = NumDigits - 1; k >= 0; k--) begin
        if (!done) begin
          segs[k] = SegOfDigit[mag % 10];
          mag = mag / 10;
          done = (mag == 0);
        end
      end
    end
    disp.digit_one   = segs[0];
    disp.digit_two   = segs[1];
    disp.digit_three = segs[2];
    disp.digit_four  = segs[3];
    disp.digit_five  = segs[4];
    disp.digit_six   = segs[5];
    return disp;
  endfunction

  task automatic check_field(string name, logic [SegWidth-1:0] want, logic [SegWidth-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_value(logic [ValueWidth-1:0] value, int unsigned idle, bit drain);
    value_item_t item;
    item.value        = value;
    item.idle_before  = idle;
    item.drain_before = drain;
    values_to_send.push_back(item);
  endtask

  // Sender: offers queued values, records the expected display of each word taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      idle_count    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        display_t disp;
        disp = encode_display(s_axis_tdata);
        pending_displays.push_back(disp);
        sent_count++;
        negative_count += disp.minus_on;
        overflow_count += disp.overflow;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (values_to_send.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (idle_count < values_to_send[0].idle_before) begin
          s_axis_tvalid <= 1'b0;
          idle_count    <= idle_count + 1;
        end else if (values_to_send[0].drain_before && pending_displays.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= values_to_send[0].value;
          void'(values_to_send.pop_front());
          idle_count    <= 0;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and two long hold-offs that back
  // the pipeline up into the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      results_taken <= 0;
      hold_left     <= 0;
      stall_left    <= 0;
      held_at       <= 0;
    end else begin
      results_taken <= results_taken + (m_axis_tvalid && m_axis_tready);
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if ((results_taken == 150 || results_taken == 600) && held_at != results_taken) begin
        held_at       <= results_taken;
        hold_left     <= LongHold;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left    <= (results_taken % 256 >= 192) ? 0 : idle_len();
      end
    end
  end

  // Monitor: every word taken is checked against the oldest expected display.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      display_t got;
      display_t want;
      got = m_axis_tdata;
      if (pending_displays.size() == 0) begin
        $error("display word 0x%0h arrived with none expected", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_displays.pop_front();
        check_field("digit_one", want.digit_one, got.digit_one);
        check_field("digit_two", want.digit_two, got.digit_two);
        check_field("digit_three", want.digit_three, got.digit_three);
        check_field("digit_four", want.digit_four, got.digit_four);
        check_field("digit_five", want.digit_five, got.digit_five);
        check_field("digit_six", want.digit_six, got.digit_six);
        check_field("minus_on", want.minus_on, got.minus_on);
        check_field("overflow", want.overflow, got.overflow);
        check_field("zero", want.zero, got.zero);
        shown_count++;
      end
    end
  end

  initial begin
    logic [ValueWidth-1:0] value;
    int unsigned           kind;
    int unsigned           idle;

    // Zero, single digits, every segment pattern, inner zeros, both edges of
    // the displayable range and the two extremes of the signed input.
    add_value(32'd0, 0, 1'b0);
    add_value(32'd1, 0, 1'b0);
    add_value(-32'sd1, 0, 1'b0);
    add_value(32'd9, 0, 1'b0);
    add_value(32'd10, 0, 1'b0);
    add_value(-32'sd5, 0, 1'b0);
    add_value(32'd42, 0, 1'b0);
    add_value(32'd100, 0, 1'b0);
    add_value(32'd1000, 0, 1'b0);
    add_value(32'd10000, 0, 1'b0);
    add_value(32'd99999, 0, 1'b0);
    add_value(32'd100000, 0, 1'b0);
    add_value(32'd123456, 0, 1'b0);
    add_value(-32'sd123456, 0, 1'b0);
    add_value(32'd987654, 0, 1'b0);
    add_value(32'd999999, 0, 1'b0);
    add_value(-32'sd999999, 0, 1'b0);
    add_value(32'd1000000, 0, 1'b0);
    add_value(-32'sd1000000, 0, 1'b0);
    add_value(32'd1000001, 0, 1'b0);
    add_value(32'h7FFF_FFFF, 0, 1'b0);
    add_value(32'h8000_0000, 0, 1'b0);

    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        value = $urandom();
      end else if (kind < 75) begin
        value = $urandom_range(0, 999999);
      end else if (kind < 90) begin
        value = $urandom_range(0, 999);
      end else begin
        value = 32'd999999 + $urandom_range(0, 4) - 2;
      end
      if (kind >= 35 && $urandom_range(0, 1)) value = -value;
      idle = ((i / 64) % 4 == 3) ? 0 : idle_len();
      add_value(value, idle, i == 0 || i == 500);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (values_to_send.size() != 0 || s_axis_tvalid || pending_displays.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Encoded %0d values (%0d negative, %0d out of range) and checked %0d displays.",
             sent_count, negative_count, overflow_count, shown_count);
    $display("Covered zero, blanked leading digits, the range edges and both signed extremes.");
    if (mismatches == 0 && pending_displays.size() == 0) begin
      $display("PASS signed_decimal_seven_segment_encoder_unit");
    end else begin
      $display("FAIL signed_decimal_seven_segment_encoder_unit");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("FAIL signed_decimal_seven_segment_encoder_unit");
    $finish;
  end

endmodule
